### rtl/ntt_r2_pkg.sv
// Shared types and constants of the radix-2 number theoretic transform block.
`timescale 1ns / 1ps
`default_nettype none

package ntt_r2_pkg;

  // Width of coefficients, moduli, roots and register data.
  localparam int DATA_W = 32;
  // Width of a full product of two coefficients.
  localparam int PROD_W = 2 * DATA_W;
  // Counter width for the bit-serial reduction (counts PROD_W down to zero).
  localparam int RED_CNT_W = $clog2(PROD_W + 1);
  // Width of the configuration register index.
  localparam int CFG_IDX_W = 3;
  // Width of the log_size register.
  localparam int LOG_SIZE_W = 4;

  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_FORWARD = 2'd1,
    MODE_INVERSE = 2'd2,
    MODE_READ    = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODULUS      = 3'd0,
    REG_FORWARD_ROOT = 3'd1,
    REG_INVERSE_ROOT = 3'd2,
    REG_SIZE_INVERSE = 3'd3,
    REG_LOG_SIZE     = 3'd4
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_READ_WAIT,
    ST_RUN_START,
    ST_BR_CHECK,
    ST_BR_RD_I,
    ST_BR_RD_J,
    ST_BR_WR_I,
    ST_BR_WR_J,
    ST_STAGE_INIT,
    ST_ROOT_WAIT,
    ST_BF_RD_TOP,
    ST_BF_RD_BOT,
    ST_BF_MUL_U,
    ST_BF_WAIT_U,
    ST_BF_WAIT_V,
    ST_BF_WR_TOP,
    ST_BF_WR_BOT,
    ST_BF_WAIT_W,
    ST_SC_RD,
    ST_SC_MUL,
    ST_SC_WAIT
  } state_t;

  // Request to the modular multiplier: start computes (a * b) mod q.
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } mm_req_t;

  // Status of the modular multiplier: done pulses for one cycle with value.
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DATA_W-1:0] value;
  } mm_rsp_t;

endpackage

`default_nettype wire

### rtl/ntt_r2_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ntt_r2_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/ntt_r2_modmul.sv
// Modular multiplier: one registered product, then bit-serial reduction mod q.
`timescale 1ns / 1ps
`default_nettype none

module ntt_r2_modmul (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ntt_r2_pkg::mm_req_t           req,
  input  wire logic [ntt_r2_pkg::DATA_W-1:0] modulus,
  output ntt_r2_pkg::mm_rsp_t                rsp
);

  localparam int DW = ntt_r2_pkg::DATA_W;
  localparam int PW = ntt_r2_pkg::PROD_W;
  localparam int CW = ntt_r2_pkg::RED_CNT_W;

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic [PW-1:0] prod;
  logic [DW-1:0] rem;

  logic [DW:0] rem_shift;
  logic [DW:0] rem_sub;
  logic        rem_ge;

  // One restoring step: shift in the next product bit, subtract q if it fits.
  assign rem_shift = {rem, prod[PW-1]};
  assign rem_ge    = rem_shift >= {1'b0, modulus};
  assign rem_sub   = rem_shift - {1'b0, modulus};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CW'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CW'(PW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      prod <= PW'(req.a) * PW'(req.b);
      rem  <= '0;
    end else if (busy) begin
      prod <= prod << 1;
      rem  <= rem_ge ? rem_sub[DW-1:0] : rem_shift[DW-1:0];
    end
  end

  assign rsp.busy  = busy;
  assign rsp.done  = done;
  assign rsp.value = rem;

endmodule

`default_nettype wire

### rtl/ntt_radix2_transform.sv
// Top level of the radix-2 decimation-in-time number theoretic transform block.
// This block holds up to 2^MAX_LOG_SIZE coefficients in one synchronous RAM and
// takes one command word at a time: load the next coefficient, run a forward or
// inverse transform in place modulo the configured prime, or read out the next
// coefficient in natural order (the read-out word carries last on entry N-1).
// A load is written to the RAM as it is accepted; a read waits for the registered
// RAM read and a free output. A word may be accepted while an earlier read-out
// word still waits on a stalled output. A run first puts the store in
// bit-reversed order (two RAM reads and two writes per swapped pair), then walks
// (N/2)*log2(N) butterflies. All modular products go through one shared multiplier
// that registers a 64-bit product and reduces it one bit per cycle. A butterfly
// reduces u, multiplies by the twiddle and advances the twiddle, with two RAM
// reads and two writes. Each stage also derives its twiddle step by repeated
// squaring of the root. An inverse run then scales every coefficient by
// size_inverse. A run with a modulus of zero leaves the store unchanged.
// Configuration is written through a plain write port and must only be changed
// while the block is idle; log_size above MAX_LOG_SIZE acts as MAX_LOG_SIZE. The
// store has no reset and must be loaded before it is read or transformed.
`timescale 1ns / 1ps
`default_nettype none

module ntt_radix2_transform #(
  parameter int MAX_LOG_SIZE = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [ntt_r2_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ntt_r2_pkg::DATA_W-1:0]    cfg_data,
  input  wire logic                             item_valid,
  output logic                                  item_stall,
  input  wire logic [1:0]                       mode,
  input  wire logic [ntt_r2_pkg::DATA_W-1:0]    coefficient,
  output logic                                  result_valid,
  input  wire logic                             result_stall,
  output logic [ntt_r2_pkg::DATA_W-1:0]         value,
  output logic                                  last
);

  localparam int DW     = ntt_r2_pkg::DATA_W;
  localparam int LSW    = ntt_r2_pkg::LOG_SIZE_W;
  localparam int ADDR_W = MAX_LOG_SIZE;
  localparam int DEPTH  = 1 << MAX_LOG_SIZE;
  // Counters that must also hold N itself.
  localparam int CNT_W  = ADDR_W + 1;
  localparam int LOG_W  = $clog2(MAX_LOG_SIZE + 1);

  // Configuration registers.
  logic [DW-1:0]  modulus;
  logic [DW-1:0]  forward_root;
  logic [DW-1:0]  inverse_root;
  logic [DW-1:0]  size_inverse;
  logic [LSW-1:0] log_size;

  // Control state.
  ntt_r2_pkg::state_t state;
  ntt_r2_pkg::state_t state_next;
  logic [ADDR_W-1:0] load_index;
  logic [ADDR_W-1:0] read_index;

  // Sequencer working registers.
  logic [ADDR_W-1:0] read_hold;
  logic              last_hold;
  logic              inverse_run;
  logic [DW-1:0]     run_root;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  base;
  logic [CNT_W-1:0]  span_pos;
  logic [CNT_W-1:0]  half;
  logic [CNT_W-1:0]  stage_exp;
  logic [CNT_W-1:0]  sq_exp;
  logic [DW-1:0]     step;
  logic [DW-1:0]     w;
  logic [DW-1:0]     u;
  logic [DW-1:0]     v;
  logic [DW-1:0]     data_a;
  logic [DW-1:0]     data_b;

  // RAM and multiplier connections.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DW-1:0]     ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DW-1:0]     ram_rdata;
  ntt_r2_pkg::mm_req_t mm_req;
  ntt_r2_pkg::mm_rsp_t mm_rsp;

  // Derived sizes and addresses.
  logic [LOG_W-1:0]  eff_log;
  logic [LOG_W-1:0]  rev_shift;
  logic [CNT_W-1:0]  n_full;
  logic [ADDR_W-1:0] mask;
  logic [ADDR_W-1:0] idx_addr;
  logic [ADDR_W-1:0] rev_full;
  logic [ADDR_W-1:0] rev_j;
  logic [CNT_W-1:0]  len;
  logic [CNT_W-1:0]  bot_full;
  logic [ADDR_W-1:0] top_addr;
  logic [ADDR_W-1:0] bot_addr;
  logic [ADDR_W-1:0] load_slot;
  logic [ADDR_W-1:0] read_slot;
  logic              accept;
  logic              out_free;
  logic              group_end;
  logic              stage_end;

  // Butterfly sum and difference, both reduced mod q.
  logic [DW:0]   sum_wide;
  logic [DW-1:0] bf_sum;
  logic [DW:0]   diff_wrap;
  logic [DW-1:0] bf_diff;

  ntt_r2_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ntt_r2_modmul u_modmul (
    .clk     (clk),
    .rst     (rst),
    .req     (mm_req),
    .modulus (modulus),
    .rsp     (mm_rsp)
  );

  assign eff_log   = (log_size > LSW'(MAX_LOG_SIZE)) ? LOG_W'(MAX_LOG_SIZE)
                                                     : LOG_W'(log_size);
  assign n_full    = CNT_W'(1) << eff_log;
  assign mask      = ADDR_W'(n_full - CNT_W'(1));
  assign idx_addr  = idx[ADDR_W-1:0];
  assign rev_shift = LOG_W'(ADDR_W) - eff_log;
  assign len       = half << 1;
  assign bot_full  = base + span_pos + half;
  assign top_addr  = ADDR_W'(base + span_pos);
  assign bot_addr  = bot_full[ADDR_W-1:0];
  assign load_slot = load_index & mask;
  assign read_slot = read_index & mask;
  assign accept    = item_valid && !item_stall;
  assign out_free  = !result_valid || !result_stall;
  assign group_end = (span_pos + CNT_W'(1)) == half;
  assign stage_end = group_end && ((base + len) == n_full);

  // Bit reversal over the full address width, then aligned to the active size.
  always_comb begin
    for (int b = 0; b < ADDR_W; b++) begin
      rev_full[b] = idx_addr[ADDR_W-1-b];
    end
    rev_j = rev_full >> rev_shift;
  end

  // u and v are both already below q, so one correction suffices for each.
  always_comb begin
    sum_wide  = {1'b0, u} + {1'b0, v};
    bf_sum    = (sum_wide >= {1'b0, modulus}) ? DW'(sum_wide - {1'b0, modulus})
                                              : sum_wide[DW-1:0];
    diff_wrap = ({1'b0, u} + {1'b0, modulus}) - {1'b0, v};
    bf_diff   = (u >= v) ? (u - v) : diff_wrap[DW-1:0];
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus      <= DW'(3329);
      forward_root <= DW'(17);
      inverse_root <= DW'(1175);
      size_inverse <= DW'(3316);
      log_size     <= LSW'(8);
    end else if (cfg_write) begin
      case (ntt_r2_pkg::reg_idx_t'(cfg_index))
        ntt_r2_pkg::REG_MODULUS:      modulus      <= cfg_data;
        ntt_r2_pkg::REG_FORWARD_ROOT: forward_root <= cfg_data;
        ntt_r2_pkg::REG_INVERSE_ROOT: inverse_root <= cfg_data;
        ntt_r2_pkg::REG_SIZE_INVERSE: size_inverse <= cfg_data;
        ntt_r2_pkg::REG_LOG_SIZE:     log_size     <= cfg_data[LSW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ntt_r2_pkg::ST_IDLE: begin
        if (accept) begin
          case (ntt_r2_pkg::mode_t'(mode))
            ntt_r2_pkg::MODE_LOAD:    state_next = ntt_r2_pkg::ST_IDLE;
            ntt_r2_pkg::MODE_FORWARD: state_next = ntt_r2_pkg::ST_RUN_START;
            ntt_r2_pkg::MODE_INVERSE: state_next = ntt_r2_pkg::ST_RUN_START;
            ntt_r2_pkg::MODE_READ:    state_next = ntt_r2_pkg::ST_READ_WAIT;
            default:                  state_next = ntt_r2_pkg::ST_IDLE;
          endcase
        end
      end
      ntt_r2_pkg::ST_READ_WAIT: begin
        if (out_free) begin
          state_next = ntt_r2_pkg::ST_IDLE;
        end
      end
      ntt_r2_pkg::ST_RUN_START: begin
        state_next = (modulus == '0) ? ntt_r2_pkg::ST_IDLE : ntt_r2_pkg::ST_BR_CHECK;
      end
      ntt_r2_pkg::ST_BR_CHECK: begin
        if (idx == n_full) begin
          state_next = ntt_r2_pkg::ST_STAGE_INIT;
        end else if (idx_addr < rev_j) begin
          state_next = ntt_r2_pkg::ST_BR_RD_I;
        end
      end
      ntt_r2_pkg::ST_BR_RD_I: state_next = ntt_r2_pkg::ST_BR_RD_J;
      ntt_r2_pkg::ST_BR_RD_J: state_next = ntt_r2_pkg::ST_BR_WR_I;
      ntt_r2_pkg::ST_BR_WR_I: state_next = ntt_r2_pkg::ST_BR_WR_J;
      ntt_r2_pkg::ST_BR_WR_J: state_next = ntt_r2_pkg::ST_BR_CHECK;
      ntt_r2_pkg::ST_STAGE_INIT: begin
        if (half < n_full) begin
          state_next = ntt_r2_pkg::ST_ROOT_WAIT;
        end else if (inverse_run) begin
          state_next = ntt_r2_pkg::ST_SC_RD;
        end else begin
          state_next = ntt_r2_pkg::ST_IDLE;
        end
      end
      ntt_r2_pkg::ST_ROOT_WAIT: begin
        if (mm_rsp.done && (sq_exp == CNT_W'(1))) begin
          state_next = ntt_r2_pkg::ST_BF_RD_TOP;
        end
      end
      ntt_r2_pkg::ST_BF_RD_TOP: state_next = ntt_r2_pkg::ST_BF_RD_BOT;
      ntt_r2_pkg::ST_BF_RD_BOT: state_next = ntt_r2_pkg::ST_BF_MUL_U;
      ntt_r2_pkg::ST_BF_MUL_U:  state_next = ntt_r2_pkg::ST_BF_WAIT_U;
      ntt_r2_pkg::ST_BF_WAIT_U: begin
        if (mm_rsp.done) begin
          state_next = ntt_r2_pkg::ST_BF_WAIT_V;
        end
      end
      ntt_r2_pkg::ST_BF_WAIT_V: begin
        if (mm_rsp.done) begin
          state_next = ntt_r2_pkg::ST_BF_WR_TOP;
        end
      end
      ntt_r2_pkg::ST_BF_WR_TOP: state_next = ntt_r2_pkg::ST_BF_WR_BOT;
      ntt_r2_pkg::ST_BF_WR_BOT: state_next = ntt_r2_pkg::ST_BF_WAIT_W;
      ntt_r2_pkg::ST_BF_WAIT_W: begin
        if (mm_rsp.done) begin
          state_next = stage_end ? ntt_r2_pkg::ST_STAGE_INIT : ntt_r2_pkg::ST_BF_RD_TOP;
        end
      end
      ntt_r2_pkg::ST_SC_RD:  state_next = ntt_r2_pkg::ST_SC_MUL;
      ntt_r2_pkg::ST_SC_MUL: state_next = ntt_r2_pkg::ST_SC_WAIT;
      ntt_r2_pkg::ST_SC_WAIT: begin
        if (mm_rsp.done) begin
          state_next = ((idx + CNT_W'(1)) == n_full) ? ntt_r2_pkg::ST_IDLE
                                                     : ntt_r2_pkg::ST_SC_RD;
        end
      end
      default: state_next = ntt_r2_pkg::ST_IDLE;
    endcase
  end

  // RAM port, multiplier requests and input stall.
  always_comb begin
    item_stall = (state != ntt_r2_pkg::ST_IDLE);
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_raddr  = '0;
    mm_req     = '0;
    case (state)
      ntt_r2_pkg::ST_IDLE: begin
        ram_raddr = read_slot;
        if (accept && (ntt_r2_pkg::mode_t'(mode) == ntt_r2_pkg::MODE_LOAD)) begin
          ram_we    = 1'b1;
          ram_waddr = load_slot;
          ram_wdata = coefficient;
        end
      end
      ntt_r2_pkg::ST_READ_WAIT: ram_raddr = read_hold;
      ntt_r2_pkg::ST_BR_RD_I:   ram_raddr = idx_addr;
      ntt_r2_pkg::ST_BR_RD_J:   ram_raddr = rev_j;
      ntt_r2_pkg::ST_BR_WR_I: begin
        ram_we    = 1'b1;
        ram_waddr = idx_addr;
        ram_wdata = ram_rdata;
      end
      ntt_r2_pkg::ST_BR_WR_J: begin
        ram_we    = 1'b1;
        ram_waddr = rev_j;
        ram_wdata = data_a;
      end
      ntt_r2_pkg::ST_STAGE_INIT: begin
        if (half < n_full) begin
          mm_req.start = 1'b1;
          mm_req.a     = run_root;
          mm_req.b     = DW'(1);
        end
      end
      ntt_r2_pkg::ST_ROOT_WAIT: begin
        if (mm_rsp.done && (sq_exp != CNT_W'(1))) begin
          mm_req.start = 1'b1;
          mm_req.a     = mm_rsp.value;
          mm_req.b     = mm_rsp.value;
        end
      end
      ntt_r2_pkg::ST_BF_RD_TOP: ram_raddr = top_addr;
      ntt_r2_pkg::ST_BF_RD_BOT: ram_raddr = bot_addr;
      ntt_r2_pkg::ST_BF_MUL_U: begin
        mm_req.start = 1'b1;
        mm_req.a     = data_a;
        mm_req.b     = DW'(1);
      end
      ntt_r2_pkg::ST_BF_WAIT_U: begin
        if (mm_rsp.done) begin
          mm_req.start = 1'b1;
          mm_req.a     = data_b;
          mm_req.b     = w;
        end
      end
      ntt_r2_pkg::ST_BF_WR_TOP: begin
        ram_we       = 1'b1;
        ram_waddr    = top_addr;
        ram_wdata    = bf_sum;
        mm_req.start = 1'b1;
        mm_req.a     = w;
        mm_req.b     = step;
      end
      ntt_r2_pkg::ST_BF_WR_BOT: begin
        ram_we    = 1'b1;
        ram_waddr = bot_addr;
        ram_wdata = bf_diff;
      end
      ntt_r2_pkg::ST_SC_RD: ram_raddr = idx_addr;
      ntt_r2_pkg::ST_SC_MUL: begin
        mm_req.start = 1'b1;
        mm_req.a     = ram_rdata;
        mm_req.b     = size_inverse;
      end
      ntt_r2_pkg::ST_SC_WAIT: begin
        if (mm_rsp.done) begin
          ram_we    = 1'b1;
          ram_waddr = idx_addr;
          ram_wdata = mm_rsp.value;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers and the output word.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ntt_r2_pkg::ST_IDLE;
      load_index   <= '0;
      read_index   <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        case (ntt_r2_pkg::mode_t'(mode))
          ntt_r2_pkg::MODE_LOAD: load_index <= (load_slot + ADDR_W'(1)) & mask;
          ntt_r2_pkg::MODE_READ: read_index <= (read_slot + ADDR_W'(1)) & mask;
          default: begin
            load_index <= '0;
            read_index <= '0;
          end
        endcase
      end
      if ((state == ntt_r2_pkg::ST_READ_WAIT) && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Sequencer working registers and output payload.
  always_ff @(posedge clk) begin
    if ((state == ntt_r2_pkg::ST_READ_WAIT) && out_free) begin
      value <= ram_rdata;
      last  <= last_hold;
    end
    case (state)
      ntt_r2_pkg::ST_IDLE: begin
        read_hold <= read_slot;
        last_hold <= (read_slot == mask);
        if (accept) begin
          inverse_run <= (ntt_r2_pkg::mode_t'(mode) == ntt_r2_pkg::MODE_INVERSE);
          run_root    <= (ntt_r2_pkg::mode_t'(mode) == ntt_r2_pkg::MODE_INVERSE)
                         ? inverse_root : forward_root;
          idx         <= '0;
          half        <= CNT_W'(1);
          stage_exp   <= n_full >> 1;
        end
      end
      ntt_r2_pkg::ST_BR_CHECK: begin
        if ((idx != n_full) && !(idx_addr < rev_j)) begin
          idx <= idx + CNT_W'(1);
        end
      end
      ntt_r2_pkg::ST_BR_RD_J: data_a <= ram_rdata;
      ntt_r2_pkg::ST_BR_WR_J: idx    <= idx + CNT_W'(1);
      ntt_r2_pkg::ST_STAGE_INIT: begin
        base     <= '0;
        span_pos <= '0;
        w        <= DW'(1);
        sq_exp   <= stage_exp;
        idx      <= '0;
      end
      ntt_r2_pkg::ST_ROOT_WAIT: begin
        if (mm_rsp.done) begin
          if (sq_exp == CNT_W'(1)) begin
            step <= mm_rsp.value;
          end else begin
            sq_exp <= sq_exp >> 1;
          end
        end
      end
      ntt_r2_pkg::ST_BF_RD_BOT: data_a <= ram_rdata;
      ntt_r2_pkg::ST_BF_MUL_U:  data_b <= ram_rdata;
      ntt_r2_pkg::ST_BF_WAIT_U: begin
        if (mm_rsp.done) begin
          u <= mm_rsp.value;
        end
      end
      ntt_r2_pkg::ST_BF_WAIT_V: begin
        if (mm_rsp.done) begin
          v <= mm_rsp.value;
        end
      end
      ntt_r2_pkg::ST_BF_WAIT_W: begin
        if (mm_rsp.done) begin
          if (group_end) begin
            // A new group restarts its twiddle at one.
            span_pos <= '0;
            w        <= DW'(1);
            if (stage_end) begin
              half      <= half << 1;
              stage_exp <= stage_exp >> 1;
            end else begin
              base <= base + len;
            end
          end else begin
            span_pos <= span_pos + CNT_W'(1);
            w        <= mm_rsp.value;
          end
        end
      end
      ntt_r2_pkg::ST_SC_WAIT: begin
        if (mm_rsp.done) begin
          idx <= idx + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  // The shared multiplier must never be restarted while it is reducing.
  assert property (@(posedge clk) disable iff (rst) mm_req.start |-> !mm_rsp.busy)
    else $error("modular multiplier restarted while busy");

  // A finished product always lands in a state that consumes it.
  assert property (@(posedge clk) disable iff (rst)
    mm_rsp.done |-> (state == ntt_r2_pkg::ST_ROOT_WAIT || state == ntt_r2_pkg::ST_BF_WAIT_U ||
                     state == ntt_r2_pkg::ST_BF_WAIT_V || state == ntt_r2_pkg::ST_BF_WAIT_W ||
                     state == ntt_r2_pkg::ST_SC_WAIT))
    else $error("modular product completed with no consumer");

  // The lower butterfly input stays inside the active transform size.
  assert property (@(posedge clk) disable iff (rst)
    (state == ntt_r2_pkg::ST_BF_RD_TOP) |-> (bot_full < n_full))
    else $error("butterfly address beyond transform size");

  // A read-out word is only produced after a read command waited for the RAM.
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == ntt_r2_pkg::ST_READ_WAIT))
    else $error("read-out word without a read command");
`endif

endmodule

`default_nettype wire

### tb/sv/tb_ntt_radix2_transform.sv
// Self-checking testbench for the radix-2 number theoretic transform block.
`timescale 1ns / 1ps
`default_nettype none

module tb_ntt_radix2_transform;

  // No word moves while a run of the largest transform is under way, so the
  // watchdog limit sits well above the length of such a run.
  localparam int SILENCE_LIMIT = 1500000;
  localparam int MAX_LOG = 8;
  localparam int DEPTH = 1 << MAX_LOG;
  localparam int RANDOM_WORDS = 1400;

  typedef struct {
    logic [ntt_r2_pkg::DATA_W-1:0] value;
    logic                          last;
  } readout_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_write = 1'b0;
  logic [ntt_r2_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ntt_r2_pkg::DATA_W-1:0]    cfg_data = '0;
  logic                             item_valid = 1'b0;
  logic                             item_stall;
  logic [1:0]                       mode = ntt_r2_pkg::MODE_LOAD;
  logic [ntt_r2_pkg::DATA_W-1:0]    coefficient = '0;
  logic                             result_valid;
  logic                             result_stall = 1'b0;
  logic [ntt_r2_pkg::DATA_W-1:0]    value;
  logic                             last;

  ntt_radix2_transform #(.MAX_LOG_SIZE(MAX_LOG)) u_top (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_stall(item_stall),
    .mode(mode), .coefficient(coefficient),
    .result_valid(result_valid), .result_stall(result_stall),
    .value(value), .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the block: registers, coefficient store and both indexes.
  // written[] tracks which entries have been loaded, so that the stimulus never
  // reads or transforms an entry whose content is undefined.
  logic [ntt_r2_pkg::DATA_W-1:0]     sh_modulus, sh_fwd_root, sh_inv_root, sh_size_inv;
  logic [ntt_r2_pkg::LOG_SIZE_W-1:0] sh_log_size;
  logic [ntt_r2_pkg::DATA_W-1:0]     sh_store [DEPTH];
  bit                                written [DEPTH];
  logic [8:0]                        sh_load_idx, sh_read_idx;

  readout_t pending_reads[$];
  int       error_count = 0;
  int       silent_cycles = 0;
  bit       calm = 1'b0;   // when set, neither side idles or stalls

  function automatic int active_log();
    return (sh_log_size > MAX_LOG) ? MAX_LOG : int'(sh_log_size);
  endfunction

  function automatic logic [8:0] index_mask();
    return 9'((1 << active_log()) - 1);
  endfunction

  function automatic logic [ntt_r2_pkg::DATA_W-1:0] mod_power(
      logic [ntt_r2_pkg::DATA_W-1:0] b,
      longint unsigned e,
      logic [ntt_r2_pkg::DATA_W-1:0] q);
    longint unsigned acc;
    longint unsigned sq;
    acc = 1;
    sq = b % q;
    while (e != 0) begin
      if (e[0]) acc = (acc * sq) % q;
      sq = (sq * sq) % q;
      e = e >> 1;
    end
    return acc[ntt_r2_pkg::DATA_W-1:0];
  endfunction

  function automatic int bit_reverse(int v, int bits);
    int r;
    r = 0;
    for (int k = 0; k < bits; k++) begin
      r = (r << 1) | (v & 1);
      v = v >> 1;
    end
    return r;
  endfunction

  // In-place transform of the shadow store, same order of operations as the
  // hardware: bit-reverse, log2(N) butterfly stages, then optional scaling.
  function automatic void transform_store(logic [ntt_r2_pkg::DATA_W-1:0] root,
                                          bit inverse);
    int lg, n, half, j;
    longint unsigned q, u, v, s, w, tw_step;
    logic [ntt_r2_pkg::DATA_W-1:0] tmp;
    lg = active_log();
    n = 1 << lg;
    q = sh_modulus;
    if (q == 0) return;
    for (int i = 0; i < n; i++) begin
      j = bit_reverse(i, lg);
      if (i < j) begin
        tmp = sh_store[i];
        sh_store[i] = sh_store[j];
        sh_store[j] = tmp;
      end
    end
    for (int len = 2; len <= n; len = len << 1) begin
      half = len >> 1;
      tw_step = mod_power(root, longint'(n / len), sh_modulus);
      for (int base = 0; base < n; base += len) begin
        w = 1;
        for (int k = 0; k < half; k++) begin
          u = sh_store[base + k] % q;
          v = (longint'(sh_store[base + k + half]) * w) % q;
          s = u + v;
          if (s >= q) s -= q;
          sh_store[base + k] = s[ntt_r2_pkg::DATA_W-1:0];
          sh_store[base + k + half] = (u >= v) ? 32'(u - v) : 32'(u + q - v);
          w = (w * tw_step) % q;
        end
      end
    end
    if (inverse) begin
      for (int i = 0; i < n; i++)
        sh_store[i] = 32'((longint'(sh_store[i]) * sh_size_inv) % q);
    end
  endfunction

  // Applies one accepted command word to the shadow copy.
  function automatic void apply_command(logic [1:0] m, logic [ntt_r2_pkg::DATA_W-1:0] c);
    logic [8:0] msk, idx;
    readout_t   r;
    msk = index_mask();
    case (m)
      ntt_r2_pkg::MODE_LOAD: begin
        idx = sh_load_idx & msk;
        sh_store[idx] = c;
        written[idx] = 1'b1;
        sh_load_idx = (idx + 9'd1) & msk;
      end
      ntt_r2_pkg::MODE_FORWARD, ntt_r2_pkg::MODE_INVERSE: begin
        transform_store(m == ntt_r2_pkg::MODE_FORWARD ? sh_fwd_root : sh_inv_root,
                        m == ntt_r2_pkg::MODE_INVERSE);
        sh_load_idx = '0;
        sh_read_idx = '0;
      end
      default: begin
        idx = sh_read_idx & msk;
        r.value = sh_store[idx];
        r.last = (idx == msk);
        pending_reads.push_back(r);
        sh_read_idx = (idx + 9'd1) & msk;
      end
    endcase
  endfunction

  function automatic bit read_allowed();
    return written[sh_read_idx & index_mask()];
  endfunction

  function automatic bit run_allowed();
    for (int i = 0; i < (1 << active_log()); i++)
      if (!written[i]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what);
    error_count++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  // Sends one command word and updates the shadow copy once it is accepted.
  // Inputs move on the falling edge; acceptance is judged at the rising edge.
  task automatic send_word(logic [1:0] m, logic [ntt_r2_pkg::DATA_W-1:0] c);
    if (!calm && $urandom_range(0, 99) < 9) begin
      item_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    item_valid = 1'b1;
    mode = m;
    coefficient = c;
    do @(posedge clk); while (item_stall);
    apply_command(m, c);
    @(negedge clk);
    item_valid = 1'b0;
  endtask

  // Waits until every read-out word has arrived, then waits on for any trailing
  // load, so that a register may be written safely.
  task automatic wait_idle();
    while (pending_reads.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_register(ntt_r2_pkg::reg_idx_t idx,
                                logic [ntt_r2_pkg::DATA_W-1:0] d);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      ntt_r2_pkg::REG_MODULUS:      sh_modulus = d;
      ntt_r2_pkg::REG_FORWARD_ROOT: sh_fwd_root = d;
      ntt_r2_pkg::REG_INVERSE_ROOT: sh_inv_root = d;
      ntt_r2_pkg::REG_SIZE_INVERSE: sh_size_inv = d;
      default:                      sh_log_size = d[ntt_r2_pkg::LOG_SIZE_W-1:0];
    endcase
  endtask

  task automatic read_words(int count);
    for (int i = 0; i < count; i++) send_word(ntt_r2_pkg::MODE_READ, $urandom());
  endtask

  task automatic load_words(int count);
    for (int i = 0; i < count; i++) send_word(ntt_r2_pkg::MODE_LOAD, $urandom());
  endtask

  // Full-size transform with the reset configuration: coefficients are mostly
  // unreduced, then the result is read out once round plus one wrapped entry.
  task automatic test_full_size_reset_config();
    load_words(DEPTH);
    send_word(ntt_r2_pkg::MODE_FORWARD, '0);
    read_words(DEPTH + 1);
  endtask

  // Field extremes at the largest modulus, load and read wrap, both runs.
  task automatic test_extremes_and_wrap();
    wait_idle();
    write_register(ntt_r2_pkg::REG_LOG_SIZE, 32'hFFFF_FFF2);   // upper data bits ignored
    write_register(ntt_r2_pkg::REG_MODULUS, 32'hFFFF_FFFF);
    write_register(ntt_r2_pkg::REG_FORWARD_ROOT, 32'hFFFF_FFFF);
    write_register(ntt_r2_pkg::REG_INVERSE_ROOT, 32'd1);
    write_register(ntt_r2_pkg::REG_SIZE_INVERSE, 32'hFFFF_FFFE);
    send_word(ntt_r2_pkg::MODE_LOAD, 32'hFFFF_FFFF);
    send_word(ntt_r2_pkg::MODE_LOAD, 32'h0000_0000);
    send_word(ntt_r2_pkg::MODE_LOAD, 32'hFFFF_FFFE);
    send_word(ntt_r2_pkg::MODE_LOAD, 32'h5555_AAAA);
    send_word(ntt_r2_pkg::MODE_LOAD, 32'hAAAA_5555);   // load wraps onto entry 0
    read_words(5);                                     // read wraps past entry N-1
    send_word(ntt_r2_pkg::MODE_FORWARD, '0);
    read_words(4);
    send_word(ntt_r2_pkg::MODE_INVERSE, '0);
    read_words(4);
  endtask

  // A transform of size one leaves the value as loaded, even above q.
  task automatic test_single_point();
    wait_idle();
    write_register(ntt_r2_pkg::REG_LOG_SIZE, 32'd0);
    write_register(ntt_r2_pkg::REG_MODULUS, 32'd3329);
    send_word(ntt_r2_pkg::MODE_LOAD, 32'd5000);
    send_word(ntt_r2_pkg::MODE_FORWARD, '0);
    read_words(2);
  endtask

  // With a zero modulus a run must leave the store untouched.
  task automatic test_zero_modulus();
    wait_idle();
    write_register(ntt_r2_pkg::REG_LOG_SIZE, 32'd1);
    write_register(ntt_r2_pkg::REG_MODULUS, 32'd0);
    load_words(2);
    send_word(ntt_r2_pkg::MODE_INVERSE, '0);
    read_words(2);
  endtask

  // Shrinking the size takes the indexes modulo the new N; a size above the
  // maximum behaves as the maximum (all entries already written by now).
  task automatic test_size_change();
    wait_idle();
    write_register(ntt_r2_pkg::REG_MODULUS, 32'd7681);
    write_register(ntt_r2_pkg::REG_LOG_SIZE, 32'd3);
    load_words(8);
    read_words(3);
    wait_idle();
    write_register(ntt_r2_pkg::REG_LOG_SIZE, 32'd2);
    read_words(2);
    wait_idle();
    write_register(ntt_r2_pkg::REG_LOG_SIZE, 32'd15);
    read_words(2);
  endtask

  function automatic logic [ntt_r2_pkg::DATA_W-1:0] pick_modulus();
    case ($urandom_range(0, 9))
      0:       return 32'hFFFF_FFFF;
      1:       return 32'd1;
      2:       return 32'd0;
      3:       return $urandom();
      4, 5:    return 32'd7681;
      6, 7:    return 32'd12289;
      default: return 32'd3329;
    endcase
  endfunction

  // Phases of random words: each one sets a new configuration, loads every entry of
  // the active size, mixes loads, reads and up to two runs, and ends on a read so
  // that the block is known to be idle before the next configuration.
  task automatic test_random_phases();
    int sent, lg, body, runs;
    int pick;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      wait_idle();
      calm = (sent >= 600 && sent < 1000);
      lg = ($urandom_range(0, 19) == 0) ? 5 : $urandom_range(0, 4);
      write_register(ntt_r2_pkg::REG_LOG_SIZE, 32'(lg));
      if ($urandom_range(0, 1))
        write_register(ntt_r2_pkg::REG_MODULUS, pick_modulus());
      if ($urandom_range(0, 1))
        write_register(ntt_r2_pkg::REG_FORWARD_ROOT, $urandom());
      if ($urandom_range(0, 1))
        write_register(ntt_r2_pkg::REG_INVERSE_ROOT, $urandom_range(1, 5000));
      if ($urandom_range(0, 1))
        write_register(ntt_r2_pkg::REG_SIZE_INVERSE, $urandom());
      for (int i = 0; i < (1 << lg); i++)
        send_word(ntt_r2_pkg::MODE_LOAD,
                  $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 13000));
      sent += 1 << lg;
      body = 2 * (1 << lg) + $urandom_range(2, 10);
      runs = 0;
      for (int i = 0; i < body; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 10 && runs < 2 && run_allowed()) begin
          send_word(pick < 5 ? ntt_r2_pkg::MODE_FORWARD : ntt_r2_pkg::MODE_INVERSE,
                    $urandom());
          runs++;
        end else if (pick < 60 && read_allowed()) begin
          send_word(ntt_r2_pkg::MODE_READ, $urandom());
        end else begin
          send_word(ntt_r2_pkg::MODE_LOAD, $urandom());
        end
      end
      sent += body;
      if (read_allowed()) read_words(1);
    end
    calm = 1'b0;
  endtask

  // Receiver side: stall at random, and check every accepted read-out word.
  always @(negedge clk)
    result_stall <= !calm && ($urandom_range(0, 99) < 9);

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_reads.size() == 0) begin
        report_mismatch($sformatf("unexpected word value=%h last=%b", value, last));
      end else begin
        readout_t exp_word;
        exp_word = pending_reads.pop_front();
        if (value !== exp_word.value)
          report_mismatch($sformatf("value %h, wanted %h", value, exp_word.value));
        if (last !== exp_word.last)
          report_mismatch($sformatf("last %b, wanted %b", last, exp_word.last));
      end
    end
  end

  // Watchdog over cycles in which no word moves on either channel.
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall))
      silent_cycles <= 0;
    else
      silent_cycles <= silent_cycles + 1;
    if (silent_cycles >= SILENCE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    sh_modulus = 32'd3329;
    sh_fwd_root = 32'd17;
    sh_inv_root = 32'd1175;
    sh_size_inv = 32'd3316;
    sh_log_size = 4'd8;
    sh_load_idx = '0;
    sh_read_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sh_store[i] = '0;
      written[i] = 1'b0;
    end
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_full_size_reset_config();
    test_extremes_and_wrap();
    test_single_point();
    test_zero_modulus();
    test_size_change();
    test_random_phases();

    while (pending_reads.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (error_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire

### ntt_radix2_transform.f
rtl/ntt_r2_pkg.sv
rtl/ntt_r2_ram.sv
rtl/ntt_r2_modmul.sv
rtl/ntt_radix2_transform.sv
tb/sv/tb_ntt_radix2_transform.sv
